// ===== design/adx_pkg.sv =====
// Shared types, constants and table functions for the downward expander.
// No dependencies; used by adx_ctrl, adx_dp and audio_downward_expander_unit.
package adx_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 40;
  localparam int LOG_STEPS   = 12;
  localparam int POW_STEPS   = 16;

  localparam logic [39:0] LEVEL_FLOOR = 40'd549755;
  localparam logic [10:0] AVG_COEF    = 11'd1678;
  localparam logic [17:0] DB_PER_LOG2 = 18'd197283;
  localparam logic signed [16:0] FLOOR_DB = -17'sd15360;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_RATIO     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_MAKEUP    = 3'd4,
    REG_BYPASS    = 3'd5,
    REG_CHANNELS  = 3'd6,
    REG_SPARE     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [14:0] threshold_db;
    logic [14:0]        expansion_ratio;
    logic [15:0]        attack_coef;
    logic [15:0]        release_coef;
    logic signed [12:0] makeup_gain_db;
    logic               bypass;
    logic [1:0]         channels_in_use;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_in;
    logic       do_sq;
    logic       do_lvl;
    logic       do_chk;
    logic       do_norm;
    logic       do_log;
    logic       do_db;
    logic       do_xl;
    logic       do_smooth;
    logic       do_exp;
    logic       do_pow;
    logic       do_scl;
    logic       do_scr;
    logic       out_load;
    logic [3:0] cnt;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic floor_hit;
    logic norm_done;
  } sts_t;

  typedef logic [30:0] pow2_tab_t [POW_STEPS];

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // c[k] = 2^(2^-(k+1)) in Q1.30, each from the square root of the last
  function automatic pow2_tab_t pow2_table();
    pow2_tab_t   t;
    logic [63:0] c;
    c = isqrt64(64'h1 << 61);
    for (int k = 0; k < POW_STEPS; k++) begin
      t[k] = c[30:0];
      c = isqrt64(c << 30);
    end
    return t;
  endfunction

  localparam pow2_tab_t POW2_C = pow2_table();

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== design/adx_ctrl.sv =====
// Sequencer for the expander: walks one item through the datapath steps.
// Depends on adx_pkg; drives adx_dp through cmd_t and reads sts_t.
module adx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  logic          bypass,
  input  adx_pkg::sts_t sts,
  output adx_pkg::cmd_t cmd
);
  import adx_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SQ     = 14'b00000000000010,
    S_LVL    = 14'b00000000000100,
    S_CHK    = 14'b00000000001000,
    S_NORM   = 14'b00000000010000,
    S_LOG    = 14'b00000000100000,
    S_DB     = 14'b00000001000000,
    S_XL     = 14'b00000010000000,
    S_SMOOTH = 14'b00000100000000,
    S_EXP    = 14'b00001000000000,
    S_POW    = 14'b00010000000000,
    S_SCL    = 14'b00100000000000,
    S_SCR    = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       out_valid;
  logic       in_acc;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign in_acc   = s_tvalid && s_tready;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = bypass ? S_OUT : S_SQ;
        end
      end
      S_SQ: begin
        cmd.do_sq  = 1'b1;
        state_next = S_LVL;
      end
      S_LVL: begin
        cmd.do_lvl = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.do_chk = 1'b1;
        state_next = sts.floor_hit ? S_XL : S_NORM;
      end
      S_NORM: begin
        cmd.do_norm = 1'b1;
        if (sts.norm_done) begin
          cnt_next   = '0;
          state_next = S_LOG;
        end
      end
      S_LOG: begin
        cmd.do_log = 1'b1;
        cnt_next   = cnt + 4'd1;
        if (cnt == 4'(LOG_STEPS - 1)) state_next = S_DB;
      end
      S_DB: begin
        cmd.do_db  = 1'b1;
        state_next = S_XL;
      end
      S_XL: begin
        cmd.do_xl  = 1'b1;
        state_next = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.do_smooth = 1'b1;
        state_next    = S_EXP;
      end
      S_EXP: begin
        cmd.do_exp = 1'b1;
        cnt_next   = '0;
        state_next = S_POW;
      end
      S_POW: begin
        cmd.do_pow = 1'b1;
        cnt_next   = cnt + 4'd1;
        if (cnt == 4'(POW_STEPS - 1)) state_next = S_SCL;
      end
      S_SCL: begin
        cmd.do_scl = 1'b1;
        state_next = S_SCR;
      end
      S_SCR: begin
        cmd.do_scr = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_SQ || state == S_OUT))
    else $error("accepted item did not start processing");
  a_log_count: assert property (@(posedge clk) disable iff (rst)
    state == S_LOG |-> cnt < 4'(LOG_STEPS))
    else $error("log step count overrun");
  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid && state == S_IDLE)
    else $error("result load did not raise valid");

endmodule

// ===== design/adx_dp.sv =====
// Datapath for the expander: level tracking, log, gain curve, smoothing,
// exponent and scaling. Depends on adx_pkg; stepped by adx_ctrl.
module adx_dp (
  input  logic          clk,
  input  adx_pkg::cfg_t cfg,
  input  adx_pkg::cmd_t cmd,
  input  logic          rst,
  input  logic [31:0]   in_data,
  output adx_pkg::sts_t sts,
  output logic [31:0]   out_data
);
  import adx_pkg::*;

  logic signed [15:0] x_l, x_r;
  logic [39:0]        sq;
  logic [39:0]        level;
  logic [39:0]        norm;
  logic [4:0]         zc;
  logic [30:0]        mreg;
  logic [11:0]        frac;
  logic signed [16:0] xg;
  logic signed [15:0] xl;
  logic signed [15:0] sred;
  logic signed [8:0]  ip;
  logic [15:0]        fp;
  logic signed [15:0] res_l, res_r;
  logic signed [15:0] out_l, out_r;
  logic               two_ch;

  assign two_ch   = cfg.channels_in_use[1];
  assign sts.floor_hit = (level <= LEVEL_FLOOR);
  assign sts.norm_done = norm[39];
  assign out_data = {out_r, out_l};

  // mix-down and square
  logic signed [16:0] mix;
  logic [33:0]        mix_sq;
  assign mix    = two_ch ? (17'(x_l) + 17'(x_r)) : (17'(x_l) <<< 1);
  assign mix_sq = 34'($signed(34'(mix)) * $signed(34'(mix)));

  // mean-square level step
  logic        lvl_up;
  logic [39:0] ldiff;
  logic [50:0] lprod;
  assign lvl_up = (sq >= level);
  assign ldiff  = lvl_up ? (sq - level) : (level - sq);
  assign lprod  = 51'(ldiff) * 51'(AVG_COEF);

  // log2 fraction by repeated squaring
  logic [61:0] lsq;
  assign lsq = 62'(mreg) * 62'(mreg);

  // log2 to dB
  logic [16:0] l2mag;
  logic [34:0] dbprod;
  assign l2mag  = {zc, 12'b0} - 17'(frac);
  assign dbprod = 35'(l2mag) * 35'(DB_PER_LOG2) + 35'(20'h80000);

  // gain computer
  logic signed [17:0] xl_diff;
  logic signed [16:0] ratio_term;
  logic signed [34:0] xl_prod;
  logic signed [34:0] xl_rnd;
  assign xl_diff    = 18'(xg) - 18'(cfg.threshold_db);
  assign ratio_term = 17'sd256 - $signed({2'b0, cfg.expansion_ratio});
  assign xl_prod    = 35'(xl_diff) * 35'(ratio_term);
  assign xl_rnd     = (xl_prod + 35'sd128) >>> 8;

  // attack / release smoothing
  logic signed [16:0] sdiff;
  logic [15:0]        alpha;
  logic signed [34:0] sm_prod;
  logic signed [34:0] sm_rnd;
  logic signed [34:0] ysum;
  assign sdiff   = 17'(sred) - 17'(xl);
  assign alpha   = (xl < sred) ? cfg.attack_coef : cfg.release_coef;
  assign sm_prod = 35'(sdiff) * $signed({19'b0, alpha});
  assign sm_rnd  = (sm_prod + 35'sd32768) >>> 16;
  assign ysum    = 35'(xl) + sm_rnd;

  // dB to log2 exponent
  logic signed [16:0] gdb;
  logic signed [40:0] eprod;
  logic signed [40:0] e_full;
  assign gdb    = 17'(cfg.makeup_gain_db) - 17'(sred);
  assign eprod  = 41'(gdb) * 41'sd2786620;
  assign e_full = (eprod + 41'sd32768) >>> 16;

  // 2^fraction step
  logic [61:0] pprod;
  assign pprod = 62'(mreg) * 62'(POW2_C[cmd.cnt]);

  // sample scaling, one channel at a time
  logic signed [15:0] xs;
  logic [16:0]        xmag;
  logic [47:0]        sp;
  logic signed [9:0]  shv;
  logic [9:0]         sh;
  logic [48:0]        sr;
  logic [48:0]        rmag;
  logic signed [15:0] sres;
  always_comb begin
    xs   = cmd.do_scr ? x_r : x_l;
    xmag = xs[15] ? (17'd0 - 17'(xs)) : 17'(xs);
    sp   = 48'(xmag) * 48'(mreg);
    shv  = 10'sd30 - 10'(ip);
    sh   = 10'($unsigned(shv));
    sr   = '0;
    if (sp == '0) begin
      rmag = '0;
    end else if (shv <= 10'sd0) begin
      rmag = 49'h1_0000;
    end else if (shv >= 10'sd48) begin
      rmag = '0;
    end else begin
      sr   = 49'(sp) + (49'd1 << (sh - 10'd1));
      rmag = sr >> sh;
    end
    if (xs[15]) begin
      sres = (rmag > 49'd32768) ? 16'sh8000 : 16'(0 - rmag[15:0]);
    end else begin
      sres = (rmag > 49'd32767) ? 16'sh7fff : rmag[15:0];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      sred  <= '0;
    end else begin
      if (cmd.do_lvl) level <= lvl_up ? (level + 40'(lprod[50:24]))
                                      : (level - 40'(lprod[50:24]));
      if (cmd.do_smooth) sred <= sat16(40'(ysum));
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_l   <= in_data[15:0];
      x_r   <= in_data[31:16];
      res_l <= in_data[15:0];
      res_r <= in_data[31:16];
    end
    if (cmd.do_sq) sq <= {mix_sq[32:0], 7'b0};
    if (cmd.do_chk) begin
      xg   <= FLOOR_DB;
      norm <= level;
      zc   <= '0;
    end
    if (cmd.do_norm) begin
      if (norm[39]) begin
        mreg <= norm[39:9];
        frac <= '0;
      end else begin
        norm <= norm << 1;
        zc   <= zc + 5'd1;
      end
    end
    if (cmd.do_log) begin
      frac <= {frac[10:0], lsq[61]};
      mreg <= lsq[61] ? lsq[61:31] : lsq[60:30];
    end
    if (cmd.do_db) xg <= -17'($signed({2'b0, dbprod[34:20]}));
    if (cmd.do_xl) xl <= (xg > 17'(cfg.threshold_db)) ? 16'sd0 : sat16(40'(xl_rnd));
    if (cmd.do_exp) begin
      ip   <= e_full[24:16];
      fp   <= e_full[15:0];
      mreg <= 31'h4000_0000;
    end
    if (cmd.do_pow && fp[4'd15 - cmd.cnt]) mreg <= pprod[60:30];
    if (cmd.do_scl) res_l <= sres;
    if (cmd.do_scr) res_r <= two_ch ? sres : 16'sd0;
    if (cmd.out_load) begin
      out_l <= res_l;
      out_r <= res_r;
    end
  end

endmodule

// ===== design/audio_downward_expander_unit.sv =====
// Downward expander top level: configuration registers and stream ports.
// Depends on adx_pkg, adx_ctrl and adx_dp.
//
// One stereo sample pair per item. With bypass clear an item goes through
// square, level, floor check, normalize, log, dB, gain curve, smoothing,
// exponent, 2^fraction and scaling; at the floor it skips from the check to
// the gain curve. The normalize shifts once per leading zero of the level,
// the log loop runs 12 squaring steps and the gain exponent 16 steps, one
// multiplier pass each. With bypass set an item goes from acceptance straight
// to the output load. The result load waits until the output register is
// free. A finished result sits in the output register while the next item
// is taken in; a new item is taken only when the sequencer is idle.
module audio_downward_expander_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_left[15:0], sample_right[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_left[15:0], out_right[31:16]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import adx_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db    <= -15'sd2560;
      cfg.expansion_ratio <= 15'd256;
      cfg.attack_coef     <= 16'd65534;
      cfg.release_coef    <= 16'd65534;
      cfg.makeup_gain_db  <= 13'sd256;
      cfg.bypass          <= 1'b0;
      cfg.channels_in_use <= 2'd2;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold_db    <= cfg_data[14:0];
        REG_RATIO:     cfg.expansion_ratio <= cfg_data[14:0];
        REG_ATTACK:    cfg.attack_coef     <= cfg_data;
        REG_RELEASE:   cfg.release_coef    <= cfg_data;
        REG_MAKEUP:    cfg.makeup_gain_db  <= cfg_data[12:0];
        REG_BYPASS:    cfg.bypass          <= cfg_data[0];
        REG_CHANNELS:  cfg.channels_in_use <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  adx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .bypass   (cfg.bypass),
    .sts      (sts),
    .cmd      (cmd)
  );

  adx_dp u_dp (
    .clk      (clk),
    .cfg      (cfg),
    .cmd      (cmd),
    .rst      (rst),
    .in_data  (s_tdata),
    .sts      (sts),
    .out_data (m_tdata)
  );

endmodule

// ===== tb/audio_downward_expander_unit_test.sv =====
// Self-checking testbench for audio_downward_expander_unit: stream driver,
// result monitor and a bit-exact gain predictor. Depends on adx_pkg and the RTL.
module audio_downward_expander_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import adx_pkg::*;

  localparam longint LVL_MASK  = (64'd1 << 40) - 1;
  localparam longint LVL_FLOOR = 549755;
  localparam longint AVG_K     = 1678;
  localparam longint DB_K      = 197283;
  localparam longint LOG2_K    = 2786620;
  localparam longint FLOOR_DBV = -15360;
  localparam int     CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  audio_downward_expander_unit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and shadow configuration
  longint thr_db, ratio, atk, rel, makeup, byp, nchan;
  longint ms_level, red_q88;

  logic [31:0] pending_items[$];
  logic [31:0] expected_out[$];
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;
  int mismatches;
  longint cycles;

  function automatic longint sx(longint v, int w);
    v = v & ((64'd1 << w) - 1);
    if (v[w-1]) v = v - (64'd1 << w);
    return v;
  endfunction

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] frac_pow2(logic [63:0] f);
    logic [63:0] m, c;
    m = 64'd1 << 30;
    c = root64(64'd1 << 61);
    for (int k = 1; k <= 16; k++) begin
      if (f[16-k]) m = (m * c) >> 30;
      c = root64(c << 30);
    end
    return m;
  endfunction

  function automatic longint level_to_db(logic [63:0] lvl);
    int p;
    logic [63:0] m, frac, mag;
    longint l2;
    p = 39;
    frac = 0;
    while (p > 0 && !lvl[p]) p--;
    m = (p >= 30) ? (lvl >> (p - 30)) : (lvl << (30 - p));
    for (int i = 0; i < 12; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    l2 = longint'(p - 39) * 4096 + longint'(frac);
    mag = -l2;
    return -longint'((mag * DB_K + (64'd1 << 19)) >> 20);
  endfunction

  function automatic longint scale_chan(longint x, logic [63:0] m, longint ip);
    logic [63:0] mag, p, r;
    longint s, sh;
    mag = (x < 0) ? -x : x;
    p = mag * m;
    s = ip - 30;
    if (p == 0) r = 0;
    else if (s >= 0) r = (s > 7) ? (64'd1 << 62) : (p << s);
    else begin
      sh = -s;
      r = (sh >= 63) ? 0 : ((p + (64'd1 << (sh - 1))) >> sh);
    end
    if (x < 0) begin
      if (r > 32768) r = 32768;
      return -longint'(r);
    end
    if (r > 32767) r = 32767;
    return longint'(r);
  endfunction

  // one sample pair through the expander; updates level and reduction unless bypassed
  function automatic logic [31:0] expand_pair(logic [31:0] din);
    longint l, r, n, a, xg, xl, y, g, e, ip, fp, ol, orr, coef;
    logic [63:0] sq, m;
    logic [15:0] ol16, or16;
    l = sx(din[15:0], 16);
    r = sx(din[31:16], 16);
    if (byp != 0) return din;
    n = nchan;
    if (n < 1) n = 1;
    if (n > 2) n = 2;
    a = (n == 2) ? (l + r) : (l * 2);
    sq = a * a;
    sq = sq << 7;
    if (sq >= ms_level) ms_level = ms_level + (((sq - ms_level) * AVG_K) >> 24);
    else ms_level = ms_level - (((ms_level - sq) * AVG_K) >> 24);
    ms_level = ms_level & LVL_MASK;
    xg = (ms_level <= LVL_FLOOR) ? FLOOR_DBV : level_to_db(ms_level);
    if (xg > thr_db) xl = 0;
    else xl = sat_word(fshift((xg - thr_db) * (256 - ratio) + 128, 8));
    coef = (xl < red_q88) ? atk : rel;
    y = sat_word(xl + fshift((red_q88 - xl) * coef + 32768, 16));
    red_q88 = y;
    g = makeup - y;
    e = fshift(g * LOG2_K + 32768, 16);
    ip = fshift(e, 16);
    fp = e - ip * 65536;
    m = frac_pow2(fp);
    ol = scale_chan(l, m, ip);
    orr = (n == 2) ? scale_chan(r, m, ip) : 0;
    ol16 = ol[15:0];
    or16 = orr[15:0];
    return {or16, ol16};
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_db = sx(val, 15);
      REG_RATIO:     ratio = val & 16'h7fff;
      REG_ATTACK:    atk = val;
      REG_RELEASE:   rel = val;
      REG_MAKEUP:    makeup = sx(val, 13);
      REG_BYPASS:    byp = val & 1;
      REG_CHANNELS:  nchan = val & 3;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_out.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic add_item(logic [15:0] lft, logic [15:0] rgt);
    pending_items.push_back({rgt, lft});
    expected_out.push_back(expand_pair({rgt, lft}));
  endtask

  // mostly quiet or moderate program material, some full-scale bursts
  task automatic random_items(int count);
    int amp;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: amp = 32767;
        1: amp = 4000;
        2: amp = 300;
        default: amp = 30;
      endcase
      add_item(16'($urandom_range(0, 2 * amp) - amp), 16'($urandom_range(0, 2 * amp) - amp));
    end
  endtask

  logic accepted_last;
  always @(posedge clk) accepted_last <= s_tvalid && s_tready;

  // item driver: changes on the falling edge; the head of the queue is
  // the item on the bus until it is accepted
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (accepted_last) void'(pending_items.pop_front());
      if ((s_tvalid && !accepted_last) ||
          (pending_items.size() != 0 &&
           $urandom_range(0, 99) >= send_idle_pct)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_items[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver readiness, with a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h", m_tdata);
      end else begin
        logic [31:0] want;
        want = expected_out.pop_front();
        if (want[15:0] !== m_tdata[15:0] || want[31:16] !== m_tdata[31:16]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: out_left exp %h got %h, out_right exp %h got %h",
                     want[15:0], m_tdata[15:0], want[31:16], m_tdata[31:16]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    hold_cycles = 0;
    send_idle_pct = 20;
    recv_idle_pct = 49;
    thr_db = -2560; ratio = 256; atk = 65534; rel = 65534;
    makeup = 256; byp = 0; nchan = 2;
    ms_level = 0; red_q88 = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes at reset settings
    add_item(16'h7fff, 16'h7fff);
    add_item(16'h8000, 16'h8000);
    add_item(16'h8000, 16'h7fff);
    add_item(16'h0000, 16'h0000);
    add_item(16'hffff, 16'h0001);
    add_item(16'h5555, 16'haaaa);
    drain();
    // mono, strong expansion, fast attack
    write_reg(REG_CHANNELS, 16'd1);
    write_reg(REG_RATIO, 16'd25600);
    write_reg(REG_ATTACK, 16'd0);
    write_reg(REG_RELEASE, 16'd65535);
    write_reg(REG_THRESHOLD, 16'(-15360));
    add_item(16'h0040, 16'h7fff);
    add_item(16'h8000, 16'h1234);
    drain();
    // threshold at top, ratio below one boosts, big makeup saturates
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_RATIO, 16'd0);
    write_reg(REG_MAKEUP, 16'd3072);
    write_reg(REG_CHANNELS, 16'd0);
    add_item(16'h0100, 16'h0000);
    add_item(16'h7fff, 16'h8000);
    add_item(16'h8000, 16'h0000);
    drain();
    write_reg(REG_CHANNELS, 16'd3);
    write_reg(REG_MAKEUP, 16'(-3072));
    write_reg(REG_RATIO, 16'h7fff);
    add_item(16'h0003, 16'hfffd);
    add_item(16'h7fff, 16'h7fff);
    drain();
    // bypass
    write_reg(REG_BYPASS, 16'd1);
    add_item(16'h8000, 16'h7fff);
    add_item(16'h1234, 16'hfedc);
    drain();
    write_reg(REG_BYPASS, 16'd0);

    // random phase 1: typical settings
    write_reg(REG_THRESHOLD, 16'(-5120));
    write_reg(REG_RATIO, 16'd768);
    write_reg(REG_ATTACK, 16'd60000);
    write_reg(REG_RELEASE, 16'd64000);
    write_reg(REG_MAKEUP, 16'd0);
    write_reg(REG_CHANNELS, 16'd2);
    random_items(450);
    // long receiver hold so the block stalls its input
    hold_cycles = 600;
    drain();

    // random phase 2: swapped idling, mono
    send_idle_pct = 49;
    recv_idle_pct = 20;
    write_reg(REG_CHANNELS, 16'd1);
    write_reg(REG_THRESHOLD, 16'(-12000));
    write_reg(REG_RATIO, 16'd5000);
    write_reg(REG_ATTACK, 16'($urandom));
    write_reg(REG_RELEASE, 16'($urandom));
    write_reg(REG_MAKEUP, 16'($urandom_range(0, 6144) - 3072));
    random_items(450);
    drain();

    // random phase 3: no idling, with short bypass stretch
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_CHANNELS, 16'd2);
    write_reg(REG_RATIO, 16'd128);
    random_items(500);
    drain();
    write_reg(REG_BYPASS, 16'd1);
    random_items(200);
    drain();

    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
